// ----- design/assert_macros.svh -----
// assertion macros shared by the circle point generator
// no dependencies; the including module must have clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define CPG_ASSERT_NEVER(label, cond, msg) \
  `CPG_ASSERT(label, !(cond), msg)

`endif

// ----- design/cpg_pkg.sv -----
// shared types and constants of the circle point generator
// no dependencies
`default_nettype none

package cpg_pkg;

  // fixed widths of the request and point fields
  localparam int unsigned IN_COORD_W = 11;
  localparam int unsigned RADIUS_W   = 10;
  localparam int unsigned PIX_W      = 13;
  localparam int unsigned DEC_W      = 16;

  // eight mirrored points per step
  localparam int unsigned POINTS = 8;
  localparam int unsigned IDX_W  = $clog2(POINTS);

  // step queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  // request operation codes
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

endpackage

`default_nettype wire

// ----- design/cpg_front.sv -----
// front end: takes requests, holds the circle state and runs the midpoint step
// depends on cpg_pkg; produces one step record per start or honored advance
`default_nettype none

module cpg_front #(
  parameter int unsigned COORD_WIDTH = 11,
  localparam int unsigned REC_W      = 4 * COORD_WIDTH + 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire cpg_pkg::op_e                      operation_i,
  input  wire logic [cpg_pkg::IN_COORD_W-1:0]    center_x_i,
  input  wire logic [cpg_pkg::IN_COORD_W-1:0]    center_y_i,
  input  wire logic [cpg_pkg::RADIUS_W-1:0]      radius_i,
  output logic                                   rec_push_o,
  output logic [REC_W-1:0]                       rec_o
);
  import cpg_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;

  logic [CW-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic [CW-1:0]    x_q, x_d, y_q, y_d;
  logic [DEC_W-1:0] d_q, d_d;
  logic             running_q, running_d;

  logic             is_start;
  logic             d_pos;
  logic [CW-1:0]    x_step, y_step;
  logic [DEC_W-1:0] diff, d_step, d_init;
  logic             done_step;

  assign is_start = (operation_i == OP_START);

  // midpoint step from the current state
  always_comb begin
    x_step    = x_q + CW'(1);
    d_pos     = !d_q[DEC_W-1] && (d_q != '0);
    y_step    = d_pos ? (y_q - CW'(1)) : y_q;
    diff      = DEC_W'(x_step) - DEC_W'($signed(y_step));
    d_step    = d_pos ? (d_q + (diff << 2) + DEC_W'(10))
                      : (d_q + (DEC_W'(x_step) << 2) + DEC_W'(6));
    done_step = $signed({y_step[CW-1], y_step}) < $signed({1'b0, x_step});
    d_init    = DEC_W'(3) - (DEC_W'(radius_i) << 1);
  end

  // next state
  always_comb begin
    cx_d      = cx_q;
    cy_d      = cy_q;
    x_d       = x_q;
    y_d       = y_q;
    d_d       = d_q;
    running_d = running_q;
    if (accept_i) begin
      if (is_start) begin
        cx_d      = CW'(center_x_i);
        cy_d      = CW'(center_y_i);
        x_d       = '0;
        y_d       = CW'(radius_i);
        d_d       = d_init;
        running_d = 1'b1;
      end else if (running_q) begin
        x_d       = x_step;
        y_d       = y_step;
        d_d       = d_step;
        running_d = !done_step;
      end
    end
  end

  // step record: {done, cy, cx, y, x}
  always_comb begin
    rec_push_o = accept_i && (is_start || running_q);
    if (is_start) begin
      rec_o = {1'b0, CW'(center_y_i), CW'(center_x_i), CW'(radius_i), {CW{1'b0}}};
    end else begin
      rec_o = {done_step, cy_q, cx_q, y_step, x_step};
    end
  end

  // circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q      <= '0;
      cy_q      <= '0;
      x_q       <= '0;
      y_q       <= '0;
      d_q       <= '0;
      running_q <= 1'b0;
    end else begin
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      x_q       <= x_d;
      y_q       <= y_d;
      d_q       <= d_d;
      running_q <= running_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/cpg_queue.sv -----
// short queue of step records between the front and the back end
// depends on cpg_pkg for its depth
`default_nettype none

module cpg_queue #(
  parameter int unsigned WIDTH = 45
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import cpg_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/cpg_back.sv -----
// back end: walks the eight mirrored points of a step record, one per cycle while
// its output register is free or being popped; depends on cpg_pkg; the output register drives the result ports
`default_nettype none

module cpg_back #(
  parameter int unsigned COORD_WIDTH = 11,
  localparam int unsigned REC_W      = 4 * COORD_WIDTH + 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [REC_W-1:0]                 rec_i,
  input  wire logic                             rec_valid_i,
  output logic                                  rec_pop_o,
  input  wire logic                             pop_i,
  output logic                                  empty_o,
  output logic signed [cpg_pkg::PIX_W-1:0]      pixel_x_o,
  output logic signed [cpg_pkg::PIX_W-1:0]      pixel_y_o,
  output logic                                  last_of_step_o,
  output logic                                  circle_done_o
);
  import cpg_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned EW = CW + PIX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS - 1);

  logic [CW-1:0]        rec_x, rec_y, rec_cx, rec_cy;
  logic                 rec_done;
  logic signed [EW-1:0] xe, ye, cxe, cye, a, b, px, py;
  logic                 load;

  logic [IDX_W-1:0]     idx_q;
  logic                 valid_q;
  logic [PIX_W-1:0]     px_q, py_q;
  logic                 last_q, done_q;

  assign {rec_done, rec_cy, rec_cx, rec_y, rec_x} = rec_i;

  // point select: bit 2 swaps x and y, bit 0 negates the column, bit 1 the row
  always_comb begin
    xe  = EW'(rec_x);
    ye  = EW'($signed(rec_y));
    cxe = EW'(rec_cx);
    cye = EW'(rec_cy);
    a   = idx_q[2] ? ye : xe;
    b   = idx_q[2] ? xe : ye;
    px  = idx_q[0] ? (cxe - a) : (cxe + a);
    py  = idx_q[1] ? (cye - b) : (cye + b);
  end

  // load the output register when it is free or being drained
  assign load      = rec_valid_i && (!valid_q || pop_i);
  assign rec_pop_o = load && (idx_q == IDX_LAST);

  // point counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
      px_q    <= '0;
      py_q    <= '0;
      last_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_q + IDX_W'(1);
        valid_q <= 1'b1;
        px_q    <= px[PIX_W-1:0];
        py_q    <= py[PIX_W-1:0];
        last_q  <= (idx_q == IDX_LAST);
        done_q  <= rec_done;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign empty_o        = !valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule

`default_nettype wire

// ----- design/circle_point_generator.sv -----
// top level of the midpoint circle point generator
// depends on cpg_pkg, cpg_front, cpg_queue, cpg_back and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// A start request (operation 0) latches center and radius and yields the eight
// points of x = 0, y = radius; an advance request (operation 1) takes one
// midpoint step and yields the eight mirrored points of the new (x, y), in the
// order (+x,+y) (-x,+y) (+x,-y) (-x,-y) (+y,+x) (-y,+x) (+y,-x) (-y,-x) around
// the center. The eighth point carries last_of_step; all eight points of the
// step that leaves y below x carry circle_done, and advances after that (or
// before any start) are accepted but yield nothing. The back end writes one
// point per cycle into the output register while that register is empty or
// being popped; the front end takes a request per cycle while the two-entry
// step queue has room. With the back end idle, the first point of a request
// is written into the step queue and then into the output register, where it
// shows on the result ports.
module circle_point_generator #(
  parameter int unsigned COORD_WIDTH = 11
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire cpg_pkg::op_e                      operation_i,
  input  wire logic [cpg_pkg::IN_COORD_W-1:0]    center_x_i,
  input  wire logic [cpg_pkg::IN_COORD_W-1:0]    center_y_i,
  input  wire logic [cpg_pkg::RADIUS_W-1:0]      radius_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [cpg_pkg::PIX_W-1:0]       pixel_x_o,
  output logic signed [cpg_pkg::PIX_W-1:0]       pixel_y_o,
  output logic                                   last_of_step_o,
  output logic                                   circle_done_o
);
  import cpg_pkg::*;

  localparam int unsigned REC_W = 4 * COORD_WIDTH + 1;

  logic             accept;
  logic             rec_push, rec_pop;
  logic [REC_W-1:0] rec_in, rec_out;
  logic             q_full, q_empty;

  // request accepted while the step queue has room
  assign accept = push && !q_full;
  assign full   = q_full;

  cpg_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .rec_push_o  (rec_push),
    .rec_o       (rec_in)
  );

  cpg_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .pop_i   (rec_pop),
    .data_o  (rec_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  cpg_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_i          (rec_out),
    .rec_valid_i    (!q_empty),
    .rec_pop_o      (rec_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

  // step queue must never overflow or underflow
  `CPG_ASSERT_NEVER(a_queue_no_overflow, rec_push && q_full, "step queue overflow")
  `CPG_ASSERT_NEVER(a_queue_no_underflow, rec_pop && q_empty, "step queue underflow")

  // points of one step share the same done flag
  `CPG_ASSERT(a_step_done_steady, (pop && !empty && !last_of_step_o) |=> (empty || (circle_done_o == $past(circle_done_o))), "done flag changed within a step")

endmodule

`default_nettype wire
